FILE: rtl/nts_pkg.sv
// nts_pkg: shared types, widths and codes for the nearest texture sampler.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package nts_pkg;

	localparam int TEXEL_DEPTH_DEF     = 65536;
	localparam int COORD_FRAC_BITS_DEF = 16;

	localparam int COORD_W   = 24;
	localparam int CEXT_W    = COORD_W + 2;
	localparam int SIZE_W    = 9;
	localparam int LIDX_W    = 16;
	localparam int TEXEL_W   = 32;
	localparam int IDX_W     = 18;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;
	localparam int MODE_W    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WRAP_S  = 2'd0,
		REG_WRAP_T  = 2'd1,
		REG_WIDTH   = 2'd2,
		REG_HEIGHT  = 2'd3
	} cfg_reg_e;

	typedef enum logic [MODE_W-1:0] {
		WRAP_REPEAT = 2'd0,
		WRAP_MIRROR = 2'd1,
		WRAP_CLAMP  = 2'd2
	} wrap_e;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_e;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] coord_u;
		logic signed [COORD_W-1:0] coord_v;
		logic [LIDX_W-1:0]         load_index;
		logic [TEXEL_W-1:0]        load_rgba;
	} in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} out_t;

	// per-beat control that travels with the data
	typedef struct packed {
		logic valid;
		logic sample;
		logic nodata;
		logic wr_ok;
	} ctl_t;

endpackage

FILE: rtl/nts_wrap.sv
// nts_wrap: wraps one signed fixed-point coordinate into [0,1] by axis mode.
// Depends on nts_pkg.
`timescale 1ns / 1ps

module nts_wrap #(
	parameter int COORD_FRAC_BITS = nts_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic signed [nts_pkg::COORD_W-1:0] coord,
	input  logic [nts_pkg::MODE_W-1:0]         mode,
	output logic [COORD_FRAC_BITS:0]           wrapped
);

	localparam int CW = nts_pkg::CEXT_W;
	localparam logic signed [CW-1:0] ONE_X = CW'(1) <<< COORD_FRAC_BITS;
	localparam logic [COORD_FRAC_BITS:0] ONE_F = (COORD_FRAC_BITS+1)'(1) << COORD_FRAC_BITS;

	logic signed [CW-1:0]          ce;
	logic [COORD_FRAC_BITS:0]      frac;
	logic                          in_rng;

	assign ce     = {{2{coord[nts_pkg::COORD_W-1]}}, coord};
	assign frac   = {1'b0, ce[COORD_FRAC_BITS-1:0]};
	assign in_rng = !ce[CW-1] && (ce <= ONE_X);

	always_comb begin
		if (in_rng) begin
			wrapped = ce[COORD_FRAC_BITS:0];
		end else begin
			unique case (nts_pkg::wrap_e'(mode))
				nts_pkg::WRAP_REPEAT: wrapped = frac;
				// floor parity sits at the first integer bit
				nts_pkg::WRAP_MIRROR: wrapped = ce[COORD_FRAC_BITS] ? (ONE_F - frac) : frac;
				default:              wrapped = ce[CW-1] ? '0 : ONE_F;
			endcase
		end
	end

endmodule

FILE: rtl/nts_addr.sv
// nts_addr: stages 2 to 6, texel coordinates, linear index and index modulo depth.
// Depends on nts_pkg.
`timescale 1ns / 1ps

module nts_addr #(
	parameter int TEXEL_DEPTH     = nts_pkg::TEXEL_DEPTH_DEF,
	parameter int COORD_FRAC_BITS = nts_pkg::COORD_FRAC_BITS_DEF,
	parameter int ADDR_W          = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  nts_pkg::ctl_t                 ctl_s1,
	input  logic [COORD_FRAC_BITS:0]      wu_s1,
	input  logic [COORD_FRAC_BITS:0]      wv_s1,
	input  logic [ADDR_W-1:0]             laddr_s1,
	input  logic [nts_pkg::TEXEL_W-1:0]   rgba_s1,
	input  logic [nts_pkg::SIZE_W-1:0]    tex_width,
	input  logic [nts_pkg::SIZE_W-1:0]    tex_height,
	output nts_pkg::ctl_t                 ctl_s6,
	output logic [ADDR_W-1:0]             addr_s6,
	output logic [nts_pkg::TEXEL_W-1:0]   rgba_s6
);

	localparam int F     = COORD_FRAC_BITS;
	localparam int SW    = nts_pkg::SIZE_W;
	localparam int IW    = nts_pkg::IDX_W;
	localparam int PW    = F + SW + 1;
	localparam int DEP_W = $clog2(TEXEL_DEPTH + 1);
	localparam int QW    = IW + DEP_W;
	localparam logic [DEP_W-1:0] DEPTH_V = DEP_W'(TEXEL_DEPTH);
	// floor(2^IW / depth): estimate is exact or one low for any IW-bit index
	localparam logic [IW:0]      RECIP   = (IW+1)'((1 << IW) / TEXEL_DEPTH);

	nts_pkg::ctl_t                ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [ADDR_W-1:0]            laddr_s2, laddr_s3, laddr_s4, laddr_s5;
	logic [nts_pkg::TEXEL_W-1:0]  rgba_s2, rgba_s3, rgba_s4, rgba_s5;
	logic [SW-1:0]                x_s2, y_s2;
	logic [IW-1:0]                idx_s3, idx_s4, qe_s4, r_s5;

	logic [SW-1:0]   wm1, hm1;
	logic [PW-1:0]   pu, pv;
	logic [IW-1:0]   lin;
	logic [2*IW:0]   pq;
	logic [QW-1:0]   qd;
	logic [IW-1:0]   rem;
	logic [31:0]     rsub;
	logic [ADDR_W-1:0] raddr;

	assign wm1 = tex_width - SW'(1);
	assign hm1 = tex_height - SW'(1);
	assign pu  = PW'(wu_s1) * PW'(wm1);
	assign pv  = PW'(wv_s1) * PW'(hm1);
	assign lin = IW'(x_s2) + IW'(y_s2) * IW'(tex_width);
	assign pq  = (2*IW+1)'(idx_s3) * (2*IW+1)'(RECIP);
	assign qd  = QW'(qe_s4) * QW'(DEPTH_V);
	assign rem = idx_s4 - IW'(qd);
	assign rsub = (32'(r_s5) >= 32'(DEPTH_V)) ? (32'(r_s5) - 32'(DEPTH_V)) : 32'(r_s5);
	assign raddr = ADDR_W'(rsub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2     <= pu[F+SW-1:F];
			y_s2     <= pv[F+SW-1:F];
			laddr_s2 <= laddr_s1;
			rgba_s2  <= rgba_s1;

			idx_s3   <= lin;
			laddr_s3 <= laddr_s2;
			rgba_s3  <= rgba_s2;

			idx_s4   <= idx_s3;
			qe_s4    <= pq[2*IW-1:IW];
			laddr_s4 <= laddr_s3;
			rgba_s4  <= rgba_s3;

			r_s5     <= rem;
			laddr_s5 <= laddr_s4;
			rgba_s5  <= rgba_s4;

			addr_s6  <= ctl_s5.sample ? raddr : laddr_s5;
			rgba_s6  <= rgba_s5;
		end
	end

endmodule

FILE: rtl/nts_texmem.sv
// nts_texmem: texel store, one write or one registered read per beat (stage 7).
// Depends on nts_pkg.
`timescale 1ns / 1ps

module nts_texmem #(
	parameter int TEXEL_DEPTH = nts_pkg::TEXEL_DEPTH_DEF,
	parameter int ADDR_W      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  nts_pkg::ctl_t                 ctl_s6,
	input  logic [ADDR_W-1:0]             addr_s6,
	input  logic [nts_pkg::TEXEL_W-1:0]   rgba_s6,
	output nts_pkg::ctl_t                 ctl_s7,
	output logic [nts_pkg::TEXEL_W-1:0]   rdata_s7
);

	logic [nts_pkg::TEXEL_W-1:0] mem [TEXEL_DEPTH];

	always_ff @(posedge clk) begin
		if (adv && ctl_s6.valid) begin
			if (ctl_s6.sample) begin
				rdata_s7 <= mem[addr_s6];
			end else if (ctl_s6.wr_ok) begin
				mem[addr_s6] <= rgba_s6;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
		end else if (adv) begin
			ctl_s7 <= ctl_s6;
		end
	end

endmodule

FILE: rtl/nearest_texture_sampler_with_wrap.sv
// nearest_texture_sampler_with_wrap: top level, config registers, wrap stage, output.
// Depends on nts_pkg, nts_wrap, nts_addr, nts_texmem.
`timescale 1ns / 1ps
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data   (nts_pkg::in_t)
// out      output     out_valid / out_stall out_data (nts_pkg::out_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat enters per cycle while in_stall is low; each sample gives one result.
// A sample passes the wrap, scale, index, modulo (3 stages) and memory read stages in turn.
// Loads write the store in stage 7, in order with samples; they give no result.
// out_stall with out_valid high freezes the whole pipe and stalls the input; nothing is lost or repeated.
// Reset clears the valid bits and config; the texel store is not cleared.

module nearest_texture_sampler_with_wrap #(
	parameter int TEXEL_DEPTH     = nts_pkg::TEXEL_DEPTH_DEF,
	parameter int COORD_FRAC_BITS = nts_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  nts_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output nts_pkg::out_t                    out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nts_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int ADDR_W = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
	localparam int F      = COORD_FRAC_BITS;

	logic [nts_pkg::MODE_W-1:0] wrap_s_q, wrap_t_q;
	logic [nts_pkg::SIZE_W-1:0] width_q, height_q;

	logic                         adv;
	logic [F:0]                   wu, wv, wu_s1, wv_s1;
	nts_pkg::ctl_t                ctl_s1, ctl_s6, ctl_s7;
	logic [ADDR_W-1:0]            laddr_s1, addr_s6;
	logic [nts_pkg::TEXEL_W-1:0]  rgba_s1, rgba_s6, rdata_s7, texel;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_s_q <= '0;
			wrap_t_q <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (nts_pkg::cfg_reg_e'(cfg_index))
				nts_pkg::REG_WRAP_S: wrap_s_q <= cfg_data[nts_pkg::MODE_W-1:0];
				nts_pkg::REG_WRAP_T: wrap_t_q <= cfg_data[nts_pkg::MODE_W-1:0];
				nts_pkg::REG_WIDTH:  width_q  <= cfg_data;
				nts_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid = ctl_s7.valid && ctl_s7.sample;
	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;

	nts_wrap #(.COORD_FRAC_BITS(F)) u_wrap_u (
		.coord   (in_data.coord_u),
		.mode    (wrap_s_q),
		.wrapped (wu)
	);

	nts_wrap #(.COORD_FRAC_BITS(F)) u_wrap_v (
		.coord   (in_data.coord_v),
		.mode    (wrap_t_q),
		.wrapped (wv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.sample <= (in_data.operation == nts_pkg::OP_SAMPLE);
			ctl_s1.nodata <= (width_q == '0) || (height_q == '0);
			ctl_s1.wr_ok  <= 32'(in_data.load_index) < 32'(TEXEL_DEPTH);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wu_s1    <= wu;
			wv_s1    <= wv;
			laddr_s1 <= ADDR_W'(in_data.load_index);
			rgba_s1  <= in_data.load_rgba;
		end
	end

	nts_addr #(
		.TEXEL_DEPTH     (TEXEL_DEPTH),
		.COORD_FRAC_BITS (F),
		.ADDR_W          (ADDR_W)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_s1     (ctl_s1),
		.wu_s1      (wu_s1),
		.wv_s1      (wv_s1),
		.laddr_s1   (laddr_s1),
		.rgba_s1    (rgba_s1),
		.tex_width  (width_q),
		.tex_height (height_q),
		.ctl_s6     (ctl_s6),
		.addr_s6    (addr_s6),
		.rgba_s6    (rgba_s6)
	);

	nts_texmem #(
		.TEXEL_DEPTH (TEXEL_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s6   (ctl_s6),
		.addr_s6  (addr_s6),
		.rgba_s6  (rgba_s6),
		.ctl_s7   (ctl_s7),
		.rdata_s7 (rdata_s7)
	);

	// no texture: all channels zero
	assign texel = ctl_s7.nodata ? '0 : rdata_s7;

	assign out_data.red   = texel[7:0];
	assign out_data.green = texel[15:8];
	assign out_data.blue  = texel[23:16];
	assign out_data.alpha = texel[31:24];

endmodule
